// File: design/vzs_pkg.sv
package vzs_pkg;

  localparam int CMD_W     = 4;
  localparam int DATA_W    = 64;
  localparam int BYTE_W    = 8;
  localparam int GROUP_W   = 7;
  localparam int MAX_BYTES = 10;
  localparam int NB_W      = 4;

  localparam logic [BYTE_W-1:0] GROUP_MASK = 8'h7F;
  localparam logic [BYTE_W-1:0] MORE_BIT   = 8'h80;
  localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_BOOL       = 4'd0,
    CMD_U8         = 4'd1,
    CMD_I8         = 4'd2,
    CMD_U16        = 4'd3,
    CMD_U32        = 4'd4,
    CMD_U64        = 4'd5,
    CMD_I16        = 4'd6,
    CMD_I32        = 4'd7,
    CMD_I64        = 4'd8,
    CMD_FLOAT      = 4'd9,
    CMD_DOUBLE     = 4'd10,
    CMD_ARRAY_BYTE = 4'd11
  } cmd_t;

  // One classified job for the back end: raw bytes or varint groups.
  typedef struct packed {
    logic              raw;
    logic [DATA_W-1:0] value;
    logic [NB_W-1:0]   nbytes;
  } work_t;

  // Number of 7-bit groups a varint needs; at least one.
  function automatic logic [NB_W-1:0] varint_len(logic [DATA_W-1:0] v);
    logic [NB_W-1:0] len;
    len = NB_W'(1);
    for (int k = 1; k < MAX_BYTES; k++) begin
      if ((v >> (GROUP_W * k)) != '0) begin
        len = NB_W'(k + 1);
      end
    end
    return len;
  endfunction

endpackage

// File: design/vzs_if.sv
interface vzs_in_if;
  logic                        valid;
  logic                        ready;
  logic [vzs_pkg::CMD_W-1:0]   command;
  logic [vzs_pkg::DATA_W-1:0]  payload;

  modport source (output valid, output command, output payload, input ready);
  modport sink   (input valid, input command, input payload, output ready);
endinterface

interface vzs_out_if;
  logic                        valid;
  logic                        ready;
  logic [vzs_pkg::BYTE_W-1:0]  out_byte;
  logic                        last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// File: design/vzs_front.sv
module vzs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  vzs_in_if.sink                     in_if,
  input  logic                       q_full,
  output logic                       q_push,
  output vzs_pkg::work_t             q_wdata
);
  import vzs_pkg::*;

  logic        known;
  logic [15:0] zz16;
  logic [31:0] zz32;
  logic [63:0] zz64;
  logic [63:0] vint;

  assign in_if.ready = !q_full;

  assign zz16 = {in_if.payload[14:0], 1'b0} ^ {16{in_if.payload[15]}};
  assign zz32 = {in_if.payload[30:0], 1'b0} ^ {32{in_if.payload[31]}};
  assign zz64 = {in_if.payload[62:0], 1'b0} ^ {64{in_if.payload[63]}};

  always_comb begin
    known         = 1'b1;
    q_wdata.raw   = 1'b1;
    q_wdata.value = in_if.payload;
    q_wdata.nbytes = NB_W'(1);
    vint          = '0;
    unique case (cmd_t'(in_if.command))
      CMD_BOOL: begin
        q_wdata.value = DATA_W'(in_if.payload != '0);
      end
      CMD_U8, CMD_I8, CMD_ARRAY_BYTE: begin
        q_wdata.nbytes = NB_W'(1);
      end
      CMD_FLOAT: begin
        q_wdata.nbytes = NB_W'(4);
      end
      CMD_DOUBLE: begin
        q_wdata.nbytes = NB_W'(8);
      end
      CMD_U16: begin
        vint = DATA_W'(in_if.payload[15:0]);
        q_wdata.raw = 1'b0;
      end
      CMD_U32: begin
        vint = DATA_W'(in_if.payload[31:0]);
        q_wdata.raw = 1'b0;
      end
      CMD_U64: begin
        vint = in_if.payload;
        q_wdata.raw = 1'b0;
      end
      CMD_I16: begin
        vint = DATA_W'(zz16);
        q_wdata.raw = 1'b0;
      end
      CMD_I32: begin
        vint = DATA_W'(zz32);
        q_wdata.raw = 1'b0;
      end
      CMD_I64: begin
        vint = zz64;
        q_wdata.raw = 1'b0;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    if (!q_wdata.raw) begin
      q_wdata.value  = vint;
      q_wdata.nbytes = varint_len(vint);
    end
  end

  // Unused codes are taken and dropped.
  assign q_push = in_if.valid && in_if.ready && known;

  a_nbytes_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_wdata.nbytes != '0 && q_wdata.nbytes <= NB_W'(MAX_BYTES)))
    else $error("front: byte count out of range");

endmodule

// File: design/vzs_queue.sv
module vzs_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vzs_pkg::work_t  wdata,
  input  logic            pop,
  output vzs_pkg::work_t  rdata,
  output logic            full,
  output logic            empty
);
  import vzs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue: push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue: pop while empty");

endmodule

// File: design/vzs_back.sv
module vzs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  vzs_pkg::work_t  q_rdata,
  input  logic            q_empty,
  output logic            q_pop,
  vzs_out_if.source       out_if
);
  import vzs_pkg::*;

  logic              busy_r, busy_nxt;
  logic              raw_r, raw_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [NB_W-1:0]   cnt_r, cnt_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;

  logic              can_emit;
  logic              at_last;
  logic              load;
  logic [BYTE_W-1:0] cur_byte;

  assign can_emit = busy_r && (!ovalid_r || out_if.ready);
  assign at_last  = (cnt_r == NB_W'(1));
  assign load     = !q_empty && (!busy_r || (can_emit && at_last));
  assign q_pop    = load;

  assign cur_byte = raw_r ? (val_r[BYTE_W-1:0] & BYTE_MASK)
                          : ((val_r[BYTE_W-1:0] & GROUP_MASK) | (at_last ? '0 : MORE_BIT));

  always_comb begin
    busy_nxt   = busy_r;
    raw_nxt    = raw_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    // drain the output register once taken
    if (out_if.ready) begin
      ovalid_nxt = 1'b0;
    end
    if (can_emit) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = cur_byte;
      olast_nxt  = at_last;
      val_nxt    = raw_r ? (val_r >> BYTE_W) : (val_r >> GROUP_W);
      cnt_nxt    = cnt_r - NB_W'(1);
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      raw_nxt  = q_rdata.raw;
      val_nxt  = q_rdata.value;
      cnt_nxt  = q_rdata.nbytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r   <= raw_nxt;
    val_r   <= val_nxt;
    cnt_r   <= cnt_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign out_if.valid     = ovalid_r;
  assign out_if.out_byte  = obyte_r;
  assign out_if.last_byte = olast_r;

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0 && cnt_r <= NB_W'(MAX_BYTES)))
    else $error("back: busy with bad remaining count");

  a_varint_more: assert property (@(posedge clk) disable iff (!rst_n)
    (can_emit && !raw_r && !at_last) |=> obyte_r[BYTE_W-1])
    else $error("back: varint continuation bit missing");

endmodule

// File: design/varint_zigzag_serializer.sv
// Typed-value serializer: one typed value in, a run of bytes out.
// Input channel (in_if): command selects the type (bool, u8/i8/array byte,
// u16/u32/u64, i16/i32/i64, float, double) and payload carries the value in
// its low bits. Unused command codes are taken and produce no bytes.
// Output channel (out_if): one byte per transaction; last_byte marks the
// final byte of each input item. Varints go out low group first with bit 7
// set on all but the last byte; signed types are zigzag-mapped first.
// The first byte of an item is written into the queue, loaded into the back-end
// registers and then registered in the output register before it is presented.
// Throughput: the back end sends one byte per cycle while out_if.ready allows;
// an item is 1 to 10 bytes (10 for a 64-bit varint at or above 2^63); items
// waiting in the queue follow back to back with no gap. The front end takes one
// item per cycle as long as the QUEUE_DEPTH-entry queue has room.
// Reset: rst_n (synchronous, active low) empties the queue, idles the back end
// and clears the output register; no other state is kept between items.
// Stall: while out_if.ready is low the output register holds its byte, the
// back end waits, the queue fills and then in_if.ready drops.
module varint_zigzag_serializer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  vzs_in_if.sink     in_if,
  vzs_out_if.source  out_if
);
  import vzs_pkg::*;

  work_t q_wdata;
  work_t q_rdata;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;

  // classify each transaction into raw bytes or varint groups
  vzs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  // decouple intake from byte emission
  vzs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // shift out one byte per cycle into the output register while out_if.ready allows
  vzs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_rdata (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule
